// File: sv/rjf_pkg.sv
`timescale 1ns / 1ps

package rjf_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    localparam logic ACT_HEADER  = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    localparam logic [6:0] CH_LBRACE = 7'h7B;
    localparam logic [6:0] CH_RBRACE = 7'h7D;
    localparam logic [6:0] CH_QUOTE  = 7'h22;
    localparam logic [6:0] CH_COLON  = 7'h3A;
    localparam logic [6:0] CH_COMMA  = 7'h2C;
    localparam logic [6:0] CH_MINUS  = 7'h2D;
    localparam logic [6:0] CH_LF     = 7'h0A;
    localparam logic [6:0] CH_CR     = 7'h0D;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_KEY_L  = 7'h4C;
    localparam logic [6:0] CH_KEY_Q  = 7'h51;
    localparam logic [6:0] CH_KEY_R  = 7'h52;
    localparam logic [6:0] CH_KEY_C  = 7'h43;
    localparam logic [6:0] CH_KEY_S  = 7'h53;
    localparam logic [6:0] CH_HEX_AF = 7'h37;   // 'A' - 10

    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    typedef enum logic [2:0] {
        FLD_L,
        FLD_Q,
        FLD_R,
        FLD_C,
        FLD_S
    } field_t;

    typedef enum logic [3:0] {
        PH_OPEN,
        PH_KEY_QUOTE,
        PH_KEY_NAME,
        PH_KEY_END,
        PH_COLON,
        PH_SIGN,
        PH_DIGIT,
        PH_COMMA,
        PH_STR_QUOTE,
        PH_HEX_HI,
        PH_HEX_LO,
        PH_CL_QUOTE,
        PH_CL_BRACE,
        PH_CL_NL,
        PH_CL_CR
    } phase_t;

    // three BCD digits, first = index of the leading printed digit
    typedef struct packed {
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
        logic [1:0] first;
    } num_t;

    typedef struct packed {
        logic           is_hdr;
        logic           close;
        logic           neg;
        logic [7:0]     byte_val;
        num_t [3:0]     num;
    } cmd_t;

    function automatic num_t to_dec(input logic [7:0] v);
        logic [19:0] sh;
        num_t        r;
        sh = {12'd0, v};
        for (int i = 0; i < 8; i++)
        begin
            if (sh[11:8] > 4'd4)
                sh[11:8] = sh[11:8] + 4'd3;
            if (sh[15:12] > 4'd4)
                sh[15:12] = sh[15:12] + 4'd3;
            if (sh[19:16] > 4'd4)
                sh[19:16] = sh[19:16] + 4'd3;
            sh = {sh[18:0], 1'b0};
        end
        r.d2 = sh[19:16];
        r.d1 = sh[15:12];
        r.d0 = sh[11:8];
        if (r.d2 != 4'd0)
            r.first = 2'd0;
        else if (r.d1 != 4'd0)
            r.first = 2'd1;
        else
            r.first = 2'd2;
        return r;
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return CH_ZERO + {3'd0, v};
        else
            return CH_HEX_AF + {3'd0, v};
    endfunction

    function automatic logic [6:0] key_char(input field_t f);
        logic [6:0] c;
        unique case (f)
            FLD_L:   c = CH_KEY_L;
            FLD_Q:   c = CH_KEY_Q;
            FLD_R:   c = CH_KEY_R;
            FLD_C:   c = CH_KEY_C;
            FLD_S:   c = CH_KEY_S;
            default: c = CH_KEY_S;
        endcase
        return c;
    endfunction

endpackage

// File: sv/rjf_front.sv
`timescale 1ns / 1ps

module rjf_front #(
    parameter int MAX_PAYLOAD = 127
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [6:0]         pkt_length,
    input  logic [7:0]         link_quality,
    input  logic signed [7:0]  signal_strength,
    input  logic [7:0]         radio_channel,
    input  logic [7:0]         payload_byte,
    input  logic               q_full,
    output logic               push,
    output rjf_pkg::cmd_t      cmd
);
    import rjf_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic       open_reg, open_next;
    logic [6:0] rem_reg, rem_next;
    logic       accept;
    logic [6:0] len_sat;
    logic [7:0] rs_mag;
    logic       byte_live;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign len_sat   = ({1'b0, pkt_length} > MAX_LEN) ? MAX_LEN[6:0] : pkt_length;
    assign rs_mag    = signal_strength[7] ? (~signal_strength + 8'd1) : signal_strength;
    assign byte_live = open_reg && (rem_reg != 7'd0);

    always_comb
    begin
        cmd.is_hdr   = (action == ACT_HEADER);
        cmd.neg      = signal_strength[7];
        cmd.byte_val = payload_byte;
        cmd.num[0]   = to_dec({1'b0, len_sat});
        cmd.num[1]   = to_dec(link_quality);
        cmd.num[2]   = to_dec(rs_mag);
        cmd.num[3]   = to_dec(radio_channel);
        cmd.close    = (action == ACT_HEADER) ? (len_sat == 7'd0) : (rem_reg == 7'd1);
    end

    assign push = accept && ((action == ACT_HEADER) || byte_live);

    always_comb
    begin
        open_next = open_reg;
        rem_next  = rem_reg;
        if (accept)
        begin
            if (action == ACT_HEADER)
            begin
                open_next = (len_sat != 7'd0);
                rem_next  = len_sat;
            end
            else if (byte_live)
            begin
                rem_next  = rem_reg - 7'd1;
                open_next = (rem_reg != 7'd1);
            end
            else
            begin
                open_next = 1'b0;
                rem_next  = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            rem_reg  <= 7'd0;
        end
        else
        begin
            open_reg <= open_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

// File: sv/rjf_queue.sv
`timescale 1ns / 1ps

module rjf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rjf_pkg::cmd_t  wr_data,
    output logic           full,
    input  logic           pop,
    output logic           rd_valid,
    output rjf_pkg::cmd_t  rd_data
);
    import rjf_pkg::*;

    localparam logic [Q_AW:0] DEPTH_CNT = (Q_AW + 1)'(Q_DEPTH);

    cmd_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic            do_push, do_pop;

    assign full     = (count_reg == DEPTH_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: sv/rjf_back.sv
`timescale 1ns / 1ps

module rjf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  rjf_pkg::cmd_t  q_data,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [6:0]     char_out,
    output logic           line_end
);
    import rjf_pkg::*;

    logic       busy_reg, busy_next;
    phase_t     phase_reg, phase_next;
    field_t     field_reg, field_next;
    logic [1:0] digit_reg, digit_next;
    cmd_t       cmd_reg, cmd_next;
    logic       out_valid_reg;
    logic [6:0] char_reg;
    logic       last_reg;

    logic       advance;
    logic       done;
    logic [1:0] fidx;
    num_t       cur_num;
    logic [6:0] cur_char;
    logic       cur_last;

    assign advance = !out_valid_reg || !out_stall;
    assign fidx    = 2'(field_reg);
    assign cur_num = cmd_reg.num[fidx];

    // sequencer: next phase within the current command, then reload
    always_comb
    begin
        phase_next = phase_reg;
        field_next = field_reg;
        digit_next = digit_reg;
        busy_next  = busy_reg;
        cmd_next   = cmd_reg;
        done       = 1'b0;
        pop        = 1'b0;
        if (busy_reg && advance)
        begin
            unique case (phase_reg)
                PH_OPEN:
                begin
                    phase_next = PH_KEY_QUOTE;
                    field_next = FLD_L;
                end
                PH_KEY_QUOTE: phase_next = PH_KEY_NAME;
                PH_KEY_NAME:  phase_next = PH_KEY_END;
                PH_KEY_END:   phase_next = PH_COLON;
                PH_COLON:
                begin
                    priority if (field_reg == FLD_S)
                        phase_next = PH_STR_QUOTE;
                    else if (field_reg == FLD_R && cmd_reg.neg)
                        phase_next = PH_SIGN;
                    else
                    begin
                        phase_next = PH_DIGIT;
                        digit_next = cur_num.first;
                    end
                end
                PH_SIGN:
                begin
                    phase_next = PH_DIGIT;
                    digit_next = cur_num.first;
                end
                PH_DIGIT:
                begin
                    if (digit_reg == 2'd2)
                        phase_next = PH_COMMA;
                    else
                        digit_next = digit_reg + 2'd1;
                end
                PH_COMMA:
                begin
                    phase_next = PH_KEY_QUOTE;
                    field_next = field_t'(field_reg + 3'd1);
                end
                PH_STR_QUOTE, PH_HEX_LO:
                begin
                    if (cmd_reg.close)
                        phase_next = PH_CL_QUOTE;
                    else
                        done = 1'b1;
                end
                PH_HEX_HI:   phase_next = PH_HEX_LO;
                PH_CL_QUOTE: phase_next = PH_CL_BRACE;
                PH_CL_BRACE: phase_next = PH_CL_NL;
                PH_CL_NL:    phase_next = PH_CL_CR;
                PH_CL_CR:    done = 1'b1;
                default:     done = 1'b1;
            endcase
        end
        if (!busy_reg || done)
        begin
            if (q_valid)
            begin
                pop        = 1'b1;
                busy_next  = 1'b1;
                cmd_next   = q_data;
                phase_next = q_data.is_hdr ? PH_OPEN : PH_HEX_HI;
            end
            else
                busy_next = 1'b0;
        end
    end

    always_comb
    begin
        cur_last = 1'b0;
        unique case (phase_reg)
            PH_OPEN:      cur_char = CH_LBRACE;
            PH_KEY_QUOTE: cur_char = CH_QUOTE;
            PH_KEY_NAME:  cur_char = key_char(field_reg);
            PH_KEY_END:   cur_char = CH_QUOTE;
            PH_COLON:     cur_char = CH_COLON;
            PH_SIGN:      cur_char = CH_MINUS;
            PH_DIGIT:
            begin
                unique case (digit_reg)
                    2'd0:    cur_char = CH_ZERO + {3'd0, cur_num.d2};
                    2'd1:    cur_char = CH_ZERO + {3'd0, cur_num.d1};
                    default: cur_char = CH_ZERO + {3'd0, cur_num.d0};
                endcase
            end
            PH_COMMA:     cur_char = CH_COMMA;
            PH_STR_QUOTE: cur_char = CH_QUOTE;
            PH_HEX_HI:    cur_char = hex_char(cmd_reg.byte_val[7:4]);
            PH_HEX_LO:    cur_char = hex_char(cmd_reg.byte_val[3:0] & NIBBLE_MASK);
            PH_CL_QUOTE:  cur_char = CH_QUOTE;
            PH_CL_BRACE:  cur_char = CH_RBRACE;
            PH_CL_NL:     cur_char = CH_LF;
            PH_CL_CR:
            begin
                cur_char = CH_CR;
                cur_last = 1'b1;
            end
            default:      cur_char = CH_CR;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (busy_reg && advance)
        begin
            char_reg <= cur_char;
            last_reg <= cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_OPEN;
            field_reg     <= FLD_L;
            digit_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            field_reg <= field_next;
            digit_reg <= digit_next;
            if (advance)
                out_valid_reg <= busy_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign line_end  = last_reg;

endmodule

// File: sv/radio_packet_json_hex_framer.sv
`timescale 1ns / 1ps

// Radio packet to JSON line framer. Each header beat becomes the text
// {"L":n,"Q":n,"R":n,"C":n,"S":" and each payload beat two upper-case hex
// digits; the last byte (or a zero-length header) appends "}, LF and CR, with
// line_end set on the CR. One character leaves per cycle from the output
// sequencer while out_stall is low. A 2-entry command queue sits between
// the input side and the sequencer: input beats are taken every cycle while
// the queue has room, so the sustained rate is set by the sequencer.
// Payload beats with no packet open are taken and dropped; a new header
// abandons any open packet without closing it.
module radio_packet_json_hex_framer #(
    parameter int MAX_PAYLOAD = 127
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [6:0]         pkt_length,
    input  logic [7:0]         link_quality,
    input  logic signed [7:0]  signal_strength,
    input  logic [7:0]         radio_channel,
    input  logic [7:0]         payload_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [6:0]         char_out,
    output logic               line_end
);
    import rjf_pkg::*;

    cmd_t push_cmd, pop_cmd;
    logic push, pop, q_full, q_valid;

    rjf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .pkt_length      (pkt_length),
        .link_quality    (link_quality),
        .signal_strength (signal_strength),
        .radio_channel   (radio_channel),
        .payload_byte    (payload_byte),
        .q_full          (q_full),
        .push            (push),
        .cmd             (push_cmd)
    );

    rjf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_data  (pop_cmd)
    );

    rjf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (pop_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .line_end  (line_end)
    );

endmodule

// File: sv/rjf_checker.sv
`timescale 1ns / 1ps

module rjf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] char_out,
    input logic       line_end
);
    import rjf_pkg::*;

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(line_end))
        else $error("output beat changed while stalled");

    a_end_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |-> char_out == CH_CR)
        else $error("line_end on a character other than CR");

    a_cr_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_out == CH_CR |-> line_end)
        else $error("CR without line_end");

    // LF is always followed directly by the closing CR
    a_lf_then_cr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && char_out == CH_LF |=>
            out_valid && char_out == CH_CR && line_end)
        else $error("LF not followed by CR");

endmodule

bind radio_packet_json_hex_framer rjf_checker u_rjf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .line_end  (line_end)
);

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import rjf_pkg::*;

    localparam int          MAX_LEN      = 127;
    localparam int          RANDOM_BEATS = 160;
    localparam int          LONG_HOLD    = 300;
    localparam int          TAIL_CYCLES  = 60;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } char_t;

    typedef struct packed {
        logic       act;
        logic [6:0] len;
        logic [7:0] lqi;
        logic [7:0] rssi;
        logic [7:0] chan;
        logic [7:0] data;
        logic       typed;   // expected text given in the plan
        logic       eol;     // typed text ends with LF, CR
    } plan_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       action = ACT_HEADER;
    logic [6:0] pkt_length = '0;
    logic [7:0] link_quality = '0;
    logic [7:0] signal_strength = '0;
    logic [7:0] radio_channel = '0;
    logic [7:0] payload_byte = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [6:0] char_out;
    logic       line_end;

    radio_packet_json_hex_framer DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .pkt_length      (pkt_length),
        .link_quality    (link_quality),
        .signal_strength (signal_strength),
        .radio_channel   (radio_channel),
        .payload_byte    (payload_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .char_out        (char_out),
        .line_end        (line_end)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // directed beats; rows with typed=0 are checked against the line predictor
    plan_row_t plan [21] = '{
        '{ACT_PAYLOAD, 7'd0,   8'd0,   8'h00, 8'd0,   8'hFF, 1'b1, 1'b0},
        '{ACT_HEADER,  7'd0,   8'd0,   8'h00, 8'd0,   8'h00, 1'b1, 1'b1},
        '{ACT_HEADER,  7'd0,   8'd255, 8'h7F, 8'd255, 8'h00, 1'b1, 1'b1},
        '{ACT_HEADER,  7'd0,   8'd9,   8'h80, 8'd10,  8'h00, 1'b1, 1'b1},
        '{ACT_HEADER,  7'd0,   8'd99,  8'hFF, 8'd100, 8'h00, 1'b1, 1'b1},
        '{ACT_HEADER,  7'd1,   8'd0,   8'h00, 8'd0,   8'h00, 1'b1, 1'b0},
        '{ACT_PAYLOAD, 7'd0,   8'd0,   8'h00, 8'd0,   8'h00, 1'b1, 1'b1},
        '{ACT_PAYLOAD, 7'd0,   8'd0,   8'h00, 8'd0,   8'hAB, 1'b1, 1'b0},
        '{ACT_HEADER,  7'd3,   8'd200, 8'hC4, 8'd15,  8'h00, 1'b0, 1'b0},
        '{ACT_PAYLOAD, 7'd0,   8'd0,   8'h00, 8'd0,   8'hFF, 1'b1, 1'b0},
        '{ACT_PAYLOAD, 7'd0,   8'd0,   8'h00, 8'd0,   8'h5A, 1'b0, 1'b0},
        '{ACT_PAYLOAD, 7'd0,   8'd0,   8'h00, 8'd0,   8'h09, 1'b1, 1'b1},
        '{ACT_HEADER,  7'd127, 8'd128, 8'h9C, 8'd11,  8'h00, 1'b1, 1'b0},
        '{ACT_PAYLOAD, 7'd0,   8'd0,   8'h00, 8'd0,   8'h3C, 1'b0, 1'b0},
        '{ACT_PAYLOAD, 7'd0,   8'd0,   8'h00, 8'd0,   8'hC3, 1'b0, 1'b0},
        '{ACT_HEADER,  7'd2,   8'd1,   8'h0A, 8'd26,  8'h00, 1'b0, 1'b0},
        '{ACT_PAYLOAD, 7'd0,   8'd0,   8'h00, 8'd0,   8'h7E, 1'b0, 1'b0},
        '{ACT_PAYLOAD, 7'd0,   8'd0,   8'h00, 8'd0,   8'h81, 1'b0, 1'b0},
        '{ACT_PAYLOAD, 7'd0,   8'd0,   8'h00, 8'd0,   8'h12, 1'b0, 1'b0},
        '{ACT_HEADER,  7'd64,  8'h55,  8'hAA, 8'h5A,  8'h00, 1'b0, 1'b0},
        '{ACT_HEADER,  7'd0,   8'h33,  8'h01, 8'hC8,  8'h00, 1'b0, 1'b0}
    };

    string plan_text [21] = '{
        "",
        "{\"L\":0,\"Q\":0,\"R\":0,\"C\":0,\"S\":\"\"}",
        "{\"L\":0,\"Q\":255,\"R\":127,\"C\":255,\"S\":\"\"}",
        "{\"L\":0,\"Q\":9,\"R\":-128,\"C\":10,\"S\":\"\"}",
        "{\"L\":0,\"Q\":99,\"R\":-1,\"C\":100,\"S\":\"\"}",
        "{\"L\":1,\"Q\":0,\"R\":0,\"C\":0,\"S\":\"",
        "00\"}",
        "",
        "",
        "FF",
        "",
        "09\"}",
        "{\"L\":127,\"Q\":128,\"R\":-100,\"C\":11,\"S\":\"",
        "", "", "", "", "", "", "", ""
    };

    // predictor state and the characters still due from the block
    logic       line_open;
    logic [6:0] bytes_due;
    char_t      beat_chars [$];
    char_t      pending_chars [$];

    int errors;
    int beats_sent;
    int headers_sent;
    int bytes_sent;
    int bytes_dropped;
    int lines_abandoned;
    int chars_checked;
    int lines_seen;
    int hold_cycles;
    bit quiet_tx;
    bit quiet_rx;
    bit hold_now;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        errors++;
    endtask

    function automatic int unsigned idle_len(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic put(input logic [6:0] c);
        beat_chars.push_back('{c, 1'b0});
    endtask

    task automatic put_key(input logic [6:0] k);
        put(CH_QUOTE);
        put(k);
        put(CH_QUOTE);
        put(CH_COLON);
    endtask

    task automatic put_dec(input int unsigned v);
        if (v >= 100)
            put(CH_ZERO + 7'(v / 100));
        if (v >= 10)
            put(CH_ZERO + 7'((v / 10) % 10));
        put(CH_ZERO + 7'(v % 10));
    endtask

    task automatic put_close();
        put(CH_QUOTE);
        put(CH_RBRACE);
        put(CH_LF);
        beat_chars.push_back('{CH_CR, 1'b1});
    endtask

    function automatic logic [6:0] hex_digit_of(input logic [3:0] nib);
        return (nib < 4'd10) ? 7'(8'h30 + nib) : 7'(8'h41 + nib - 4'd10);
    endfunction

    // characters of the JSON line caused by one accepted beat
    task automatic frame_beat(input logic act, input logic [6:0] len_in,
                              input logic [7:0] lqi, input logic [7:0] rssi,
                              input logic [7:0] chan, input logic [7:0] data);
        int unsigned len;
        beat_chars.delete();
        if (act == ACT_HEADER)
        begin
            headers_sent++;
            if (line_open)
                lines_abandoned++;
            len = (len_in > MAX_LEN) ? MAX_LEN : len_in;
            put(CH_LBRACE);
            put_key(CH_KEY_L);
            put_dec(len);
            put(CH_COMMA);
            put_key(CH_KEY_Q);
            put_dec(lqi);
            put(CH_COMMA);
            put_key(CH_KEY_R);
            if (rssi[7])
            begin
                put(CH_MINUS);
                put_dec(256 - int'(rssi));
            end
            else
                put_dec(rssi);
            put(CH_COMMA);
            put_key(CH_KEY_C);
            put_dec(chan);
            put(CH_COMMA);
            put_key(CH_KEY_S);
            put(CH_QUOTE);
            if (len == 0)
            begin
                put_close();
                line_open = 1'b0;
                bytes_due = '0;
            end
            else
            begin
                line_open = 1'b1;
                bytes_due = 7'(len);
            end
        end
        else
        begin
            bytes_sent++;
            if (!line_open || bytes_due == 0)
            begin
                line_open = 1'b0;
                bytes_due = '0;
                bytes_dropped++;
            end
            else
            begin
                put(hex_digit_of(data[7:4]));
                put(hex_digit_of(data[3:0]));
                bytes_due = bytes_due - 7'd1;
                if (bytes_due == 0)
                begin
                    put_close();
                    line_open = 1'b0;
                end
            end
        end
    endtask

    // offer one beat, wait for it to be taken, queue its characters, then idle
    task automatic send_beat(input logic act, input logic [6:0] len,
                             input logic [7:0] lqi, input logic [7:0] rssi,
                             input logic [7:0] chan, input logic [7:0] data,
                             input bit typed, input string text, input bit eol);
        int unsigned gap;
        in_valid        <= 1'b1;
        action          <= act;
        pkt_length      <= len;
        link_quality    <= lqi;
        signal_strength <= rssi;
        radio_channel   <= chan;
        payload_byte    <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        frame_beat(act, len, lqi, rssi, chan, data);
        beats_sent++;
        if (typed)
        begin
            for (int i = 0; i < text.len(); i++)
                pending_chars.push_back('{7'(text[i]), 1'b0});
            if (eol)
            begin
                pending_chars.push_back('{CH_LF, 1'b0});
                pending_chars.push_back('{CH_CR, 1'b1});
            end
        end
        else
        begin
            foreach (beat_chars[i])
                pending_chars.push_back(beat_chars[i]);
        end
        gap = idle_len(quiet_tx);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(input logic act, input logic [6:0] len);
        send_beat(act, len, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                  8'($urandom()), 1'b0, "", 1'b0);
    endtask

    // sender waits until every queued character has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial
    begin : rx_stall
        int unsigned n;
        forever
        begin
            if (hold_now)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                hold_now = 1'b0;
            end
            else
            begin
                n = idle_len(quiet_rx);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : char_check
        char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
                flag_mismatch($sformatf("char 0x%02h with nothing pending", char_out));
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (char_out !== want.ch)
                    flag_mismatch($sformatf("char #%0d: got 0x%02h want 0x%02h",
                                            chars_checked, char_out, want.ch));
                if (line_end !== want.last)
                    flag_mismatch($sformatf("char #%0d: line_end got %b want %b",
                                            chars_checked, line_end, want.last));
                if (line_end === 1'b1)
                    lines_seen++;
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d chars pending", cycles, pending_chars.size());
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int          pkt;
        int          n_bytes;
        int unsigned len;
        int unsigned r;
        line_open = 1'b0;
        bytes_due = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        for (int i = 0; i < $size(plan); i++)
            send_beat(plan[i].act, plan[i].len, plan[i].lqi, plan[i].rssi, plan[i].chan,
                      plan[i].data, plan[i].typed, plan_text[i], plan[i].eol);
        drain();

        pkt = 0;
        while (beats_sent < $size(plan) + RANDOM_BEATS)
        begin
            if (pkt == 2)
                drain();
            if (pkt == 4)
            begin
                // back-to-back beats against a stalled receiver fill the block
                quiet_tx = 1'b1;
                hold_now = 1'b1;
            end
            if (pkt == 8)
                quiet_tx = 1'b0;
            if (pkt == 10)
            begin
                quiet_tx = 1'b1;
                quiet_rx = 1'b1;
            end
            if (pkt == 14)
            begin
                quiet_tx = 1'b0;
                quiet_rx = 1'b0;
            end

            // stray bytes between packets
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 2)) send_random(ACT_PAYLOAD, 7'($urandom()));

            len = ($urandom_range(0, 24) == 0) ? $urandom_range(7, 127) : $urandom_range(0, 6);
            send_random(ACT_HEADER, 7'(len));
            r = $urandom_range(0, 9);
            if (r == 0)
                n_bytes = $urandom_range(0, len);           // cut short by the next header
            else if (r == 1)
                n_bytes = len + $urandom_range(1, 3);       // extra bytes after the close
            else
                n_bytes = len;
            repeat (n_bytes)
                if (beats_sent < $size(plan) + RANDOM_BEATS)
                    send_random(ACT_PAYLOAD, 7'($urandom()));
            pkt++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d beats: %0d headers, %0d payload bytes (%0d dropped), %0d lines cut",
                 beats_sent, headers_sent, bytes_sent, bytes_dropped, lines_abandoned);
        $display("checked %0d chars over %0d closed lines; receiver held off %0d cycles",
                 chars_checked, lines_seen, hold_cycles);
        if (errors == 0 && pending_chars.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: radio_packet_json_hex_framer.f
sv/rjf_pkg.sv
sv/rjf_front.sv
sv/rjf_queue.sv
sv/rjf_back.sv
sv/radio_packet_json_hex_framer.sv
sv/rjf_checker.sv
bench/tb.sv
